// File: rtl/e2q_pkg.sv
// e2q_pkg: shared types, constants and CORDIC arctangent table for euler_to_quaternion.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

  localparam int TrigIterationsDefault = 16;
  localparam int AtanEntries = 24;

  // Angle formats: half angle held with 2^28 codes per radian
  localparam logic signed [33:0] PiQ28     = 34'sd843314857;
  localparam logic signed [33:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;
  localparam logic signed [47:0] OneQ14    = 48'sd16384;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } quat_t;

  // Folded half angle and cosine sign, handed from front to back
  typedef struct packed {
    logic signed [33:0] z;
    logic               flip;
  } fold_t;

  typedef struct packed {
    fold_t r;
    fold_t p;
    fold_t y;
  } folded_t;

  function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0:  v = 34'sd210828714;
      5'd1:  v = 34'sd124459457;
      5'd2:  v = 34'sd65760959;
      5'd3:  v = 34'sd33381290;
      5'd4:  v = 34'sd16755422;
      5'd5:  v = 34'sd8385879;
      5'd6:  v = 34'sd4193963;
      5'd7:  v = 34'sd2097109;
      5'd8:  v = 34'sd1048571;
      5'd9:  v = 34'sd524287;
      5'd10: v = 34'sd262144;
      5'd11: v = 34'sd131072;
      5'd12: v = 34'sd65536;
      5'd13: v = 34'sd32768;
      5'd14: v = 34'sd16384;
      5'd15: v = 34'sd8192;
      5'd16: v = 34'sd4096;
      5'd17: v = 34'sd2048;
      5'd18: v = 34'sd1024;
      5'd19: v = 34'sd512;
      5'd20: v = 34'sd256;
      5'd21: v = 34'sd128;
      5'd22: v = 34'sd64;
      5'd23: v = 34'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp to plus or minus one in Q1.14
  function automatic logic signed [15:0] clamp_one(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > OneQ14) r = 16'sd16384;
    else if (v < -OneQ14) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/e2q_front.sv
// e2q_front: accepts angle transfers, halves and folds each angle into +-pi/2.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2q_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire e2q_pkg::angles_t   in_data,
  output logic                    f_valid,
  input  wire logic               f_ready,
  output e2q_pkg::folded_t        f_data
);
  import e2q_pkg::*;

  function automatic fold_t fold(input logic signed [15:0] a);
    fold_t f;
    logic signed [33:0] z;
    z = 34'(a) <<< 14;
    f.flip = 1'b1;
    if (z > HalfPiQ28) f.z = PiQ28 - z;
    else if (z < -HalfPiQ28) f.z = -PiQ28 - z;
    else begin
      f.z = z;
      f.flip = 1'b0;
    end
    return f;
  endfunction

  // Single output register, refilled in the cycle it drains
  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_data.r <= fold(in_data.roll_angle);
      f_data.p <= fold(in_data.pitch_angle);
      f_data.y <= fold(in_data.yaw_angle);
    end
  end
endmodule
`default_nettype wire

// File: rtl/e2q_queue.sv
// e2q_queue: two-entry queue between front and back.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2q_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_valid,
  output logic                    s_ready,
  input  wire e2q_pkg::folded_t   s_data,
  output logic                    m_valid,
  input  wire logic               m_ready,
  output e2q_pkg::folded_t        m_data
);
  import e2q_pkg::*;

  folded_t    mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign s_ready = count != 2'd2;
  assign m_valid = count != 2'd0;
  assign m_data  = mem[rp];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= s_data;
  end
endmodule
`default_nettype wire

// File: rtl/e2q_back.sv
// e2q_back: pipelined CORDIC for the three half angles, then triple products.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2q_back #(
  parameter int TrigIterations = e2q_pkg::TrigIterationsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire e2q_pkg::folded_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output e2q_pkg::quat_t          out_data
);
  import e2q_pkg::*;

  localparam int Steps = (TrigIterations < AtanEntries) ? TrigIterations : AtanEntries;
  // CORDIC stages, trig rounding, pair product, triple product, sum
  localparam int Depth = Steps + 4;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } rot_t;

  logic [Depth:1] vld;
  logic           adv;

  // Whole pipe moves together when the output is free
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  rot_t rin [3];
  rot_t rs [3][1:Steps];

  always_comb begin
    rin[0] = '{x: GainQ30, y: '0, z: in_data.r.z, flip: in_data.r.flip};
    rin[1] = '{x: GainQ30, y: '0, z: in_data.p.z, flip: in_data.p.flip};
    rin[2] = '{x: GainQ30, y: '0, z: in_data.y.z, flip: in_data.y.flip};
  end

  // One CORDIC step per stage
  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar i = 0; i < Steps; i++) begin : g_step
      rot_t               cur;
      logic signed [33:0] dx, dy;
      if (i == 0) begin : g_first
        assign cur = rin[a];
      end else begin : g_chain
        assign cur = rs[a][i];
      end
      assign dx = cur.y >>> i;
      assign dy = cur.x >>> i;
      always_ff @(posedge clk) begin
        if (adv) begin
          rs[a][i+1].flip <= cur.flip;
          if (!cur.z[33]) begin
            rs[a][i+1].x <= cur.x - dx;
            rs[a][i+1].y <= cur.y + dy;
            rs[a][i+1].z <= cur.z - atan_q28(5'(i));
          end else begin
            rs[a][i+1].x <= cur.x + dx;
            rs[a][i+1].y <= cur.y - dy;
            rs[a][i+1].z <= cur.z + atan_q28(5'(i));
          end
        end
      end
    end
  end

  // Rounded Q1.14 sine and cosine: index 0 roll, 1 pitch, 2 yaw
  logic signed [15:0] sn [3];
  logic signed [15:0] cs [3];
  for (genvar a = 0; a < 3; a++) begin : g_trig
    logic signed [33:0] xr, yr;
    logic signed [15:0] c0;
    assign xr = (rs[a][Steps].x + 34'sd32768) >>> 16;
    assign yr = (rs[a][Steps].y + 34'sd32768) >>> 16;
    assign c0 = clamp_one(48'(xr));
    always_ff @(posedge clk) begin
      if (adv) begin
        sn[a] <= clamp_one(48'(yr));
        cs[a] <= rs[a][Steps].flip ? -c0 : c0;
      end
    end
  end

  // Pair products (Q28) with third factor carried along
  logic signed [31:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [15:0] t_cy, t_sy;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cc <= cs[0] * cs[1];
      p_ss <= sn[0] * sn[1];
      p_sc <= sn[0] * cs[1];
      p_cs <= cs[0] * sn[1];
      t_cy <= cs[2];
      t_sy <= sn[2];
    end
  end

  // Triple products (Q42)
  logic signed [47:0] m_sccy, m_cssy, m_cscy, m_scsy, m_ccsy, m_sscy, m_cccy, m_sssy;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_sccy <= 48'(p_sc) * 48'(t_cy);
      m_cssy <= 48'(p_cs) * 48'(t_sy);
      m_cscy <= 48'(p_cs) * 48'(t_cy);
      m_scsy <= 48'(p_sc) * 48'(t_sy);
      m_ccsy <= 48'(p_cc) * 48'(t_sy);
      m_sscy <= 48'(p_ss) * 48'(t_cy);
      m_cccy <= 48'(p_cc) * 48'(t_cy);
      m_sssy <= 48'(p_ss) * 48'(t_sy);
    end
  end

  function automatic logic signed [15:0] finish(input logic signed [47:0] s);
    logic signed [47:0] r;
    r = (s + 48'sd134217728) >>> 28;
    return clamp_one(r);
  endfunction

  // Sums, rounding and saturation into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.quat_x <= finish(m_sccy - m_cssy);
      out_data.quat_y <= finish(m_cscy + m_scsy);
      out_data.quat_z <= finish(m_ccsy - m_sscy);
      out_data.quat_w <= finish(m_cccy + m_sssy);
    end
  end

  // Valid flags travel alongside the data
  assign out_valid = vld[Depth];
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-1:1], in_valid};
    end
  end
endmodule
`default_nettype wire

// File: rtl/euler_to_quaternion.sv
// euler_to_quaternion: top level, front fold stage, queue and pipelined back end.
// Depends on e2q_pkg, e2q_front, e2q_queue, e2q_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------
//  in       | in_valid / in_ready     | in_data  (e2q_pkg::angles_t)
//  out      | out_valid / out_ready   | out_data (e2q_pkg::quat_t)
//
// One transfer per cycle sustained while out_ready stays high; a result passes through the
// fold register, the queue, one CORDIC step per stage, trig round, two multiplies and
// sum before it is valid.
// rst is synchronous and clears the valid flags and the queue pointers.
// A stall at the output freezes the back pipeline; the queue then fills and
// finally the front stops taking input.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion #(
  parameter int TrigIterations = e2q_pkg::TrigIterationsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire e2q_pkg::angles_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output e2q_pkg::quat_t          out_data
);
  import e2q_pkg::*;

  logic    f_valid, f_ready, q_valid, q_ready;
  folded_t f_data, q_data;

  e2q_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .f_valid, .f_ready, .f_data
  );

  e2q_queue u_queue (
    .clk, .rst,
    .s_valid(f_valid), .s_ready(f_ready), .s_data(f_data),
    .m_valid(q_valid), .m_ready(q_ready), .m_data(q_data)
  );

  e2q_back #(.TrigIterations(TrigIterations)) u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

// File: tb/testbench.sv
// testbench: self-checking bench for euler_to_quaternion (Euler ZYX to unit quaternion).
// Depends on e2q_pkg and the euler_to_quaternion RTL; predicts each result bit for bit.
`timescale 1ns / 1ps

// Expected quaternions in arrival order, checked against the block's output
class quat_scoreboard;
  e2q_pkg::quat_t pending[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned unexpected;

  function new();
    mismatches = 0;
    checked = 0;
    unexpected = 0;
  endfunction

  // CORDIC sine and cosine of half an angle code, Q1.14
  function automatic void half_trig(input logic signed [15:0] ang,
                                    output logic signed [15:0] sn,
                                    output logic signed [15:0] cs);
    longint z, x, y, nx, dx, dy, a;
    bit flip;
    int n;
    z = longint'(ang) * 16384;
    x = 652032874;
    y = 0;
    flip = 0;
    n = e2q_pkg::TrigIterationsDefault;
    if (n > e2q_pkg::AtanEntries) n = e2q_pkg::AtanEntries;
    if (z > 421657428) begin
      z = 843314857 - z;
      flip = 1;
    end else if (z < -421657428) begin
      z = -843314857 - z;
      flip = 1;
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      a = longint'(e2q_pkg::atan_q28(i[4:0]));
      if (z >= 0) begin
        nx = x - dx;
        y = y + dy;
        z = z - a;
      end else begin
        nx = x + dx;
        y = y - dy;
        z = z + a;
      end
      x = nx;
    end
    cs = sat_q14((x + 32768) >>> 16);
    sn = sat_q14((y + 32768) >>> 16);
    if (flip) cs = -cs;
  endfunction

  function automatic logic signed [15:0] sat_q14(input longint v);
    if (v > 16384) return 16'sd16384;
    if (v < -16384) return -16'sd16384;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] round_q42(input longint v);
    return sat_q14((v + (longint'(1) <<< 27)) >>> 28);
  endfunction

  // Note an accepted set of angles and queue its quaternion
  function void note_angles(input e2q_pkg::angles_t a);
    logic signed [15:0] sr, cr, sp, cp, sy, cy;
    longint lsr, lcr, lsp, lcp, lsy, lcy;
    e2q_pkg::quat_t q;
    half_trig(a.roll_angle, sr, cr);
    half_trig(a.pitch_angle, sp, cp);
    half_trig(a.yaw_angle, sy, cy);
    lsr = sr; lcr = cr; lsp = sp; lcp = cp; lsy = sy; lcy = cy;
    q.quat_x = round_q42(lsr * lcp * lcy - lcr * lsp * lsy);
    q.quat_y = round_q42(lcr * lsp * lcy + lsr * lcp * lsy);
    q.quat_z = round_q42(lcr * lcp * lsy - lsr * lsp * lcy);
    q.quat_w = round_q42(lcr * lcp * lcy + lsr * lsp * lsy);
    pending.push_back(q);
  endfunction

  // Compare one output transfer with the oldest expectation
  function void check_quat(input e2q_pkg::quat_t got);
    e2q_pkg::quat_t exp_q;
    if (pending.size() == 0) begin
      unexpected++;
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
      return;
    end
    exp_q = pending.pop_front();
    checked++;
    if (got !== exp_q) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d x/y/z/w exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                 checked, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z, exp_q.quat_w,
                 got.quat_x, got.quat_y, got.quat_z, got.quat_w);
    end
  endfunction
endclass

module testbench;
  localparam int Latency = 30;
  localparam int CycleLimit = 200000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  e2q_pkg::angles_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  e2q_pkg::quat_t out_data;

  quat_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit long_hold = 0;
  bit stim_done = 0;

  euler_to_quaternion u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Note accepted inputs and check accepted outputs at the edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_angles(in_data);
    if (!rst && out_valid && out_ready) sb.check_quat(out_data);
  end

  // Send one set of angles after a random gap, hold until transfer;
  // valid stays high on return so back-to-back transfers need no second drive
  task automatic send_angles(input logic signed [15:0] r, p, y);
    int gap;
    gap = $urandom_range(0, 4);
    if (sent % 150 > 110) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{roll_angle: r, pitch_angle: p, yaw_angle: y};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [15:0] rand_angle();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom());
    if (k == 1) return 16'(int'($urandom_range(0, 64)) - 32);
    return 16'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (200) @(posedge clk);
        long_hold = 0;
      end
      gap = $urandom_range(0, 4);
      if ((cycles / 500) % 3 == 2) gap = 0;
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap - 1) @(posedge clk);
        @(posedge clk);
      end
      out_ready <= 1;
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin
    logic signed [15:0] corners [10];
    corners = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                16'sd12869, -16'sd12869, 16'sh7fff, 16'sh8000, 16'sd1};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes, half-turn fold boundaries, quarter turns and raw 16-bit extremes
    for (int i = 0; i < 10; i++) send_angles(corners[i], corners[(i+3)%10], corners[(i+7)%10]);
    send_angles(16'sd25736, 16'sd25736, 16'sd25736);
    send_angles(-16'sd25736, -16'sd25736, -16'sd25736);
    send_angles(16'sd0, 16'sd12868, 16'sd0);
    send_angles(16'shffff, 16'sh5555, 16'shaaaa);
    send_angles(16'sh7fff, 16'sh7fff, 16'sh8000);
    in_valid <= 0;
    // Sender pauses until the block drains
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // Long receiver hold-off while items keep coming
    long_hold = 1;
    for (int i = 0; i < 60; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
    for (int i = 0; i < 640; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
    in_valid <= 0;
    stim_done = 1;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("Sent %0d angle sets incl. fold boundaries and raw 16-bit codes; %0d results checked.",
             sent, sb.checked);
    if (sb.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
